>>> design/kwsc_pkg.sv
package kwsc_pkg;

  localparam int unsigned Letters = 26;
  localparam int unsigned IdxW    = 5;

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5A;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerZ = 8'h7A;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Letters - 1);
  localparam logic [IdxW-1:0] NumIdx  = IdxW'(Letters);

  localparam logic [2:0] CmdKeyStart  = 3'd0;
  localparam logic [2:0] CmdKeyLetter = 3'd1;
  localparam logic [2:0] CmdKeyFinish = 3'd2;
  localparam logic [2:0] CmdEncrypt   = 3'd3;
  localparam logic [2:0] CmdDecrypt   = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StIgnored  = 2'd1;
  localparam logic [1:0] StNotReady = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } letter_t;

  // Case-folded alphabet position of an ASCII byte.
  function automatic letter_t letter_index(input logic [7:0] b);
    letter_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (b >= AsciiUpperA && b <= AsciiUpperZ) begin
      d       = b - AsciiUpperA;
      r.valid = 1'b1;
      r.idx   = d[IdxW-1:0];
    end else if (b >= AsciiLowerA && b <= AsciiLowerZ) begin
      d       = b - AsciiLowerA;
      r.valid = 1'b1;
      r.idx   = d[IdxW-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/kwsc_ram.sv
module kwsc_ram #(
  parameter int unsigned Depth = 26,
  parameter int unsigned Width = 5,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/keyword_substitution_cipher_top.sv
// Key start, key letter, unused codes and lookups on non-letters or before the key
// is ready: result in the cycle after accept. Lookup: one read of the map RAM, then
// the result register. Key finish walks all 26 entries. Lookups and key finish block
// input; otherwise one item per cycle while the output is not stalled.
// Reset (async, active low) clears used letters, fill slot, key-ready and the
// output valid; the map RAMs are not cleared and are fully written by key finish.
module keyword_substitution_cipher_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // slave side
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0] s_axis_tuser,   // [2:0] cmd
  // master side
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser    // [1:0] status
);

  localparam int unsigned IdxW = kwsc_pkg::IdxW;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StFill
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [kwsc_pkg::Letters-1:0] used_q, used_d;
  logic [IdxW-1:0]              fill_q, fill_d;
  logic                         ready_q, ready_d;
  logic [IdxW-1:0]              walk_q, walk_d;   // walk counter, reaches Letters
  logic                         dec_q, dec_d;     // pending lookup is a decrypt

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [1:0] out_status_q, out_status_d;

  kwsc_pkg::letter_t li;
  logic              accept;
  logic              out_free;

  // map RAM ports; forward written at the fill slot, inverse at the letter
  logic            map_we;
  logic [IdxW-1:0] map_letter;
  logic            map_re;
  logic [IdxW-1:0] fwd_rdata;
  logic [IdxW-1:0] inv_rdata;
  logic [IdxW-1:0] lookup;

  assign li       = kwsc_pkg::letter_index(s_axis_tdata);
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;

  kwsc_ram #(
    .Depth (kwsc_pkg::Letters),
    .Width (IdxW)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (fill_q),
    .wdata_i (map_letter),
    .re_i    (map_re),
    .raddr_i (li.idx),
    .rdata_o (fwd_rdata)
  );

  kwsc_ram #(
    .Depth (kwsc_pkg::Letters),
    .Width (IdxW)
  ) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_letter),
    .wdata_i (fill_q),
    .re_i    (map_re),
    .raddr_i (li.idx),
    .rdata_o (inv_rdata)
  );

  // out-of-range map entries read as the first letter
  assign lookup = dec_q ? inv_rdata : fwd_rdata;

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    fill_d       = fill_q;
    ready_d      = ready_q;
    walk_d       = walk_q;
    dec_d        = dec_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    map_we       = 1'b0;
    map_letter   = li.idx;
    map_re       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_byte_d   = '0;
          out_status_d = kwsc_pkg::StOk;
          unique case (s_axis_tuser) inside
            kwsc_pkg::CmdKeyStart: begin
              used_d      = '0;
              fill_d      = '0;
              ready_d     = 1'b0;
              out_valid_d = 1'b1;
            end
            kwsc_pkg::CmdKeyLetter: begin
              out_valid_d = 1'b1;
              if (ready_q || !li.valid || used_q[li.idx]) begin
                out_status_d = kwsc_pkg::StIgnored;
              end else if (fill_q < kwsc_pkg::NumIdx) begin
                map_we          = 1'b1;
                used_d[li.idx]  = 1'b1;
                fill_d          = fill_q + 1'b1;
              end
            end
            kwsc_pkg::CmdKeyFinish: begin
              walk_d  = '0;
              state_d = StFill;
            end
            kwsc_pkg::CmdEncrypt, kwsc_pkg::CmdDecrypt: begin
              if (!ready_q) begin
                out_byte_d   = s_axis_tdata;
                out_status_d = kwsc_pkg::StNotReady;
                out_valid_d  = 1'b1;
              end else if (!li.valid) begin
                out_byte_d  = s_axis_tdata;
                out_valid_d = 1'b1;
              end else begin
                map_re  = 1'b1;
                dec_d   = (s_axis_tuser == kwsc_pkg::CmdDecrypt);
                state_d = StLookup;
              end
            end
            default: begin
              out_status_d = kwsc_pkg::StIgnored;
              out_valid_d  = 1'b1;
            end
          endcase
        end
      end

      StLookup: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = kwsc_pkg::StOk;
          out_byte_d   = (lookup > kwsc_pkg::LastIdx) ? kwsc_pkg::AsciiUpperA :
                         kwsc_pkg::AsciiUpperA + 8'(lookup);
          state_d      = StIdle;
        end
      end

      StFill: begin
        map_letter = walk_q;
        if (walk_q < kwsc_pkg::NumIdx) begin
          // append each unused letter in alphabetical order
          if (!used_q[walk_q] && fill_q < kwsc_pkg::NumIdx) begin
            map_we         = 1'b1;
            used_d[walk_q] = 1'b1;
            fill_d         = fill_q + 1'b1;
          end
          walk_d = walk_q + 1'b1;
        end else if (out_free) begin
          ready_d      = 1'b1;
          out_valid_d  = 1'b1;
          out_byte_d   = '0;
          out_status_d = kwsc_pkg::StOk;
          state_d      = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      fill_q      <= '0;
      ready_q     <= 1'b0;
      walk_q      <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      ready_q     <= ready_d;
      walk_q      <= walk_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_status_q;

endmodule

>>> tb/sv/keyword_substitution_cipher_top_test.sv
module keyword_substitution_cipher_top_test;

  // Command codes the block treats as unused
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  localparam int unsigned RandomItems = 1850;
  localparam int unsigned IdlePct     = 35;
  localparam int unsigned HoldCycles  = 300;
  // Key finish is the slowest item; drain a bit longer than it takes
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
  } cipher_res_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data;
    logic        typed;  // res holds a hand-written expectation
    cipher_res_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic [2:0] s_axis_tuser;   // [2:0] cmd
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic [1:0] m_axis_tuser;   // [1:0] status

  keyword_substitution_cipher_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of the cipher state
  logic [kwsc_pkg::IdxW-1:0]    enc_table [kwsc_pkg::Letters];
  logic [kwsc_pkg::IdxW-1:0]    dec_table [kwsc_pkg::Letters];
  logic [kwsc_pkg::Letters-1:0] placed_mask;
  logic [kwsc_pkg::IdxW-1:0]    next_slot;
  logic                         key_done;

  cipher_res_t cipher_q [$];    // expected results, oldest first
  stim_row_t   directed_rows [$];
  cipher_res_t head_res;

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned counted_items;
  bit          calm;              // no idling on either side
  bit          hold_off_pending;  // ask the receiver for one long stall
  bit          hold_off_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Append the next cipher letter at the fill slot
  function automatic void place_letter(input logic [kwsc_pkg::IdxW-1:0] idx);
    if (next_slot < kwsc_pkg::NumIdx) begin
      enc_table[next_slot] = idx;
      dec_table[idx]       = next_slot;
      placed_mask[idx]     = 1'b1;
      next_slot            = next_slot + 1'b1;
    end
  endfunction

  // Advance the shadow state by one item and return its result
  function automatic cipher_res_t cipher_predict(input logic [2:0] cmd,
                                                 input logic [7:0] b);
    cipher_res_t               r;
    logic                      is_upper;
    logic                      is_lower;
    logic [7:0]                ofs;
    logic [kwsc_pkg::IdxW-1:0] idx;
    r        = '0;
    is_upper = (b >= kwsc_pkg::AsciiUpperA) && (b <= kwsc_pkg::AsciiUpperZ);
    is_lower = (b >= kwsc_pkg::AsciiLowerA) && (b <= kwsc_pkg::AsciiLowerZ);
    ofs      = is_upper ? (b - kwsc_pkg::AsciiUpperA) : (b - kwsc_pkg::AsciiLowerA);
    idx      = ofs[kwsc_pkg::IdxW-1:0];
    case (cmd) inside
      kwsc_pkg::CmdKeyStart: begin
        placed_mask = '0;
        next_slot   = '0;
        key_done    = 1'b0;
        r.status    = kwsc_pkg::StOk;
      end
      kwsc_pkg::CmdKeyLetter: begin
        if (key_done || !(is_upper || is_lower) || placed_mask[idx]) begin
          r.status = kwsc_pkg::StIgnored;
        end else begin
          place_letter(idx);
          r.status = kwsc_pkg::StOk;
        end
      end
      kwsc_pkg::CmdKeyFinish: begin
        for (int i = 0; i < kwsc_pkg::Letters; i++) begin
          if (!placed_mask[i]) place_letter(kwsc_pkg::IdxW'(i));
        end
        key_done = 1'b1;
        r.status = kwsc_pkg::StOk;
      end
      kwsc_pkg::CmdEncrypt, kwsc_pkg::CmdDecrypt: begin
        if (!key_done) begin
          r.out_byte = b;
          r.status   = kwsc_pkg::StNotReady;
        end else if (!(is_upper || is_lower)) begin
          r.out_byte = b;
          r.status   = kwsc_pkg::StOk;
        end else begin
          r.out_byte = kwsc_pkg::AsciiUpperA +
                       ((cmd == kwsc_pkg::CmdEncrypt) ? enc_table[idx] : dec_table[idx]);
          r.status   = kwsc_pkg::StOk;
        end
      end
      default: begin
        r.status = kwsc_pkg::StIgnored;
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [7:0] data,
                                  input logic typed, input logic [7:0] ob,
                                  input logic [1:0] st);
    stim_row_t row;
    row.cmd          = cmd;
    row.data         = data;
    row.typed        = typed;
    row.res.out_byte = ob;
    row.res.status   = st;
    directed_rows.push_back(row);
  endfunction

  // Offer one item, wait for its acceptance, then queue its expectation.
  // Called at a rising edge; returns at the edge that accepted the item.
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                           input logic typed, input cipher_res_t given);
    cipher_res_t pred;
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    // Ready is sampled mid-cycle, where nothing is changing
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    pred = cipher_predict(cmd, data);
    cipher_q.push_back(typed ? given : pred);
    counted_items++;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] pos;
    pos = 8'($urandom_range(kwsc_pkg::Letters - 1));
    return $urandom_range(1) ? (kwsc_pkg::AsciiUpperA + pos) :
                               (kwsc_pkg::AsciiLowerA + pos);
  endfunction

  // Mostly letters, the rest any byte
  function automatic logic [7:0] rand_text();
    return ($urandom_range(99) < 75) ? rand_letter() : 8'($urandom_range(255));
  endfunction

  function automatic logic [2:0] rand_lookup();
    return $urandom_range(1) ? kwsc_pkg::CmdEncrypt : kwsc_pkg::CmdDecrypt;
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_pending && !hold_off_done) begin
        hold_off_done = 1'b1;
        repeat (HoldCycles) begin
          m_axis_tready <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Result check, sampled mid-cycle for the transfer at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: out_byte %h status %0d",
                   m_axis_tdata, m_axis_tuser);
      end else begin
        head_res = cipher_q.pop_front();
        if (m_axis_tdata !== head_res.out_byte || m_axis_tuser !== head_res.status) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: out_byte exp %h got %h, status exp %0d got %0d",
                     head_res.out_byte, m_axis_tdata, head_res.status, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    logic [2:0]  c;
    cipher_res_t none;

    none             = '0;
    counted_items    = 0;
    calm             = 1'b0;
    hold_off_pending = 1'b0;
    placed_mask      = '0;
    next_slot        = '0;
    key_done         = 1'b0;
    for (int i = 0; i < kwsc_pkg::Letters; i++) begin
      enc_table[i] = '0;
      dec_table[i] = '0;
    end
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = kwsc_pkg::CmdKeyStart;

    // Lookups before any key pass the byte through; bad letters and spare codes are ignored
    add_row(kwsc_pkg::CmdEncrypt,   8'h41, 1'b1, 8'h41, kwsc_pkg::StNotReady);
    add_row(kwsc_pkg::CmdDecrypt,   8'hFF, 1'b1, 8'hFF, kwsc_pkg::StNotReady);
    add_row(kwsc_pkg::CmdEncrypt,   8'h00, 1'b1, 8'h00, kwsc_pkg::StNotReady);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h00, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(CmdSpare5,              8'h5A, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(CmdSpare7,              8'hFF, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    // Finish straight after reset: identity alphabet
    add_row(kwsc_pkg::CmdKeyFinish, 8'h00, 1'b1, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdEncrypt,   8'h7A, 1'b1, 8'h5A, kwsc_pkg::StOk);
    // Letter after finish is dropped, a second finish changes nothing
    add_row(kwsc_pkg::CmdKeyLetter, 8'h51, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyFinish, 8'hFF, 1'b1, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdKeyStart,  8'h00, 1'b1, 8'h00, kwsc_pkg::StOk);
    // Keyword "ZA": duplicates and bytes just outside the letter ranges
    add_row(kwsc_pkg::CmdKeyLetter, 8'h7A, 1'b0, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h5A, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h61, 1'b0, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h40, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h5B, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h60, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyLetter, 8'h7B, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyLetter, 8'hFF, 1'b1, 8'h00, kwsc_pkg::StIgnored);
    add_row(kwsc_pkg::CmdKeyFinish, 8'h00, 1'b1, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdEncrypt,   8'h41, 1'b0, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdEncrypt,   8'h40, 1'b1, 8'h40, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdDecrypt,   8'h5A, 1'b0, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdDecrypt,   8'h61, 1'b0, 8'h00, kwsc_pkg::StOk);
    add_row(kwsc_pkg::CmdDecrypt,   8'h80, 1'b1, 8'h80, kwsc_pkg::StOk);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].res);

    counted_items = 0;
    while (counted_items < RandomItems) begin
      // One quiet stretch; the receiver stalls at its start so the input backs up
      calm = (counted_items >= 600) && (counted_items < 900);
      if (calm) hold_off_pending = 1'b1;
      pick = $urandom_range(99);
      if (pick < 75) begin
        // Full key setup, then a run of text
        send_item(kwsc_pkg::CmdKeyStart, 8'($urandom_range(255)), 1'b0, none);
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (n)
          send_item(kwsc_pkg::CmdKeyLetter,
                    ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_letter(),
                    1'b0, none);
        send_item(kwsc_pkg::CmdKeyFinish, 8'($urandom_range(255)), 1'b0, none);
        repeat ($urandom_range(5, 40)) begin
          if ($urandom_range(99) < 4)
            c = $urandom_range(1) ? kwsc_pkg::CmdKeyLetter : kwsc_pkg::CmdKeyFinish;
          else
            c = rand_lookup();
          send_item(c, rand_text(), 1'b0, none);
        end
      end else if (pick < 88) begin
        // Key started but never finished: lookups see no key
        send_item(kwsc_pkg::CmdKeyStart, 8'($urandom_range(255)), 1'b0, none);
        repeat ($urandom_range(6))
          send_item(kwsc_pkg::CmdKeyLetter, rand_letter(), 1'b0, none);
        repeat ($urandom_range(1, 6))
          send_item(rand_lookup(), rand_text(), 1'b0, none);
      end else begin
        // Noise: any command code, any byte
        repeat ($urandom_range(1, 8))
          send_item(3'($urandom_range(7)), 8'($urandom_range(255)), 1'b0, none);
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
